FILE: src/mip_pkg.sv
`default_nettype none
package mip_pkg;

   localparam int MAX_LEN_DEF = 512;
   localparam int QUEUE_DEPTH = 4;
   localparam int INS_W = 9;
   localparam logic [INS_W-1:0] INS_MAX = 9'd511;

   typedef struct packed {
      logic [7:0] ch;
      logic       last;
   } req_word_type;

   typedef struct packed {
      logic [INS_W-1:0] insertions;
      logic             too_long;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef struct packed {
      logic sweeping;
      logic pop;
      logic pop_last;
   } bk_status_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_SWEEP,
      BK_DRAIN
   } bk_state_type;

endpackage
`default_nettype wire

FILE: src/mip_front.sv
`default_nettype none
module mip_front
   import mip_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF,
   parameter int ENT_W = 8 + $clog2(MAX_LEN) + $clog2(MAX_LEN + 1) + 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               accept,
   input  wire req_word_type       word,
   output logic [ENT_W-1:0]        entry
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);

   typedef struct packed {
      logic [7:0]    ch;
      logic [AW-1:0] addr;
      logic [LW-1:0] len;
      logic          keep;
      logic          last;
      logic          too_long;
   } entry_type;

   logic [LW-1:0] count_ff, count_in;
   logic          ovf_ff, ovf_in;
   logic          keep;
   logic [LW-1:0] next_count;
   entry_type     ent;

   always_comb begin
      keep = count_ff < LW'(MAX_LEN);
      next_count = keep ? count_ff + LW'(1) : count_ff;
      ent.ch = word.ch;
      ent.addr = count_ff[AW-1:0];
      ent.len = next_count;
      ent.keep = keep;
      ent.last = word.last;
      ent.too_long = ovf_ff | ~keep;
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (accept) begin
         if (word.last) begin
            count_in = '0;
            ovf_in = 1'b0;
         end else begin
            count_in = next_count;
            ovf_in = ovf_ff | ~keep;
         end
      end
   end

   assign entry = ent;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         ovf_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         ovf_ff <= ovf_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/mip_queue.sv
`default_nettype none
module mip_queue
   import mip_pkg::*;
#(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output q_status_type          status
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = PW + 1;

   logic [WIDTH-1:0] slot_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   assign status.full = count_ff == CW'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/mip_back.sv
`default_nettype none
module mip_back
   import mip_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF,
   parameter int ENT_W = 8 + $clog2(MAX_LEN) + $clog2(MAX_LEN + 1) + 3
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire q_status_type       q_stat,
   input  wire logic [ENT_W-1:0]   entry,
   output logic                    pop,
   output bk_status_type           stat,
   output logic                    rsp_strobe,
   output rsp_word_type            rsp_word
);

   localparam int AW = $clog2(MAX_LEN);
   localparam int LW = $clog2(MAX_LEN + 1);
   localparam int VW = AW;
   localparam int EW = (VW > INS_W) ? VW : INS_W;

   typedef struct packed {
      logic [7:0]    ch;
      logic [AW-1:0] addr;
      logic [LW-1:0] len;
      logic          keep;
      logic          last;
      logic          too_long;
   } entry_type;

   entry_type     ent;

   logic [7:0]    char_mem  [MAX_LEN];
   logic [VW-1:0] diag0_mem [MAX_LEN];
   logic [VW-1:0] diag1_mem [MAX_LEN];

   bk_state_type  state_ff, state_in;
   logic [LW-1:0] n_ff, n_in;
   logic [LW-1:0] len_ff, len_in;
   logic [AW-1:0] rd_ff, rd_in;
   logic          too_long_ff, too_long_in;
   logic          ret_ff, cell_ff;
   logic [AW-1:0] rdq_ff;
   logic [7:0]    ca_ff, cb_ff;
   logic [VW-1:0] d0_rd_ff, d1_rd_ff;
   logic [VW-1:0] win_ff;
   logic          rsp_strobe_ff, rsp_strobe_in;
   rsp_word_type  rsp_ff, rsp_in;

   logic          issue;
   logic          last_rd;
   logic          last_diag;
   logic [LW-1:0] span;
   logic [LW-1:0] cb_sum;
   logic [AW-1:0] ca_addr, cb_addr;
   logic [AW-1:0] cell_idx;
   logic [VW-1:0] newer_rd, older_rd, nv, ov, mn, cell_val;
   logic [EW-1:0] val_ext;
   logic [INS_W-1:0] sat_val;

   assign ent = entry;

   always_comb begin
      span = n_ff - len_ff;
      last_rd = LW'(rd_ff) == span;
      last_diag = len_ff + LW'(1) == n_ff;
      ca_addr = rd_ff - AW'(1);
      cb_sum = LW'(rd_ff) + len_ff - LW'(1);
      cb_addr = cb_sum[AW-1:0];
      cell_idx = rdq_ff - AW'(1);
      newer_rd = len_ff[0] ? d0_rd_ff : d1_rd_ff;
      older_rd = len_ff[0] ? d1_rd_ff : d0_rd_ff;
      nv = (len_ff == LW'(1)) ? '0 : newer_rd;
      ov = (len_ff <= LW'(2)) ? '0 : older_rd;
      mn = (win_ff < nv) ? win_ff : nv;
      cell_val = (ca_ff == cb_ff) ? ov : mn + VW'(1);
      val_ext = EW'(cell_val);
      sat_val = (val_ext > EW'(INS_MAX)) ? INS_MAX : val_ext[INS_W-1:0];
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (!q_stat.empty && ent.last && ent.len != LW'(1)) begin
               state_in = BK_SWEEP;
            end
         end
         BK_SWEEP: begin
            if (last_rd) begin
               state_in = BK_DRAIN;
            end
         end
         BK_DRAIN: begin
            state_in = last_diag ? BK_IDLE : BK_SWEEP;
         end
         default: begin
            state_in = BK_IDLE;
         end
      endcase
   end

   always_comb begin
      pop = 1'b0;
      issue = 1'b0;
      n_in = n_ff;
      len_in = len_ff;
      rd_in = rd_ff;
      too_long_in = too_long_ff;
      rsp_strobe_in = 1'b0;
      rsp_in = rsp_ff;
      case (state_ff)
         BK_IDLE: begin
            pop = !q_stat.empty;
            if (pop && ent.last) begin
               n_in = ent.len;
               len_in = LW'(1);
               rd_in = '0;
               too_long_in = ent.too_long;
               if (ent.len == LW'(1)) begin
                  rsp_strobe_in = 1'b1;
                  rsp_in.insertions = '0;
                  rsp_in.too_long = ent.too_long;
               end
            end
         end
         BK_SWEEP: begin
            issue = 1'b1;
            if (!last_rd) begin
               rd_in = rd_ff + AW'(1);
            end
         end
         BK_DRAIN: begin
            len_in = len_ff + LW'(1);
            rd_in = '0;
            if (last_diag) begin
               rsp_strobe_in = 1'b1;
               rsp_in.insertions = sat_val;
               rsp_in.too_long = too_long_ff;
            end
         end
         default: begin
            pop = 1'b0;
         end
      endcase
   end

   assign stat.sweeping = state_ff != BK_IDLE;
   assign stat.pop = pop;
   assign stat.pop_last = pop & ent.last;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_word = rsp_ff;

   always_ff @(posedge clock) begin
      if (pop && ent.keep) begin
         char_mem[ent.addr] <= ent.ch;
      end
      ca_ff <= char_mem[ca_addr];
      cb_ff <= char_mem[cb_addr];
   end

   always_ff @(posedge clock) begin
      if (cell_ff && !len_ff[0]) begin
         diag0_mem[cell_idx] <= cell_val;
      end
      d0_rd_ff <= diag0_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      if (cell_ff && len_ff[0]) begin
         diag1_mem[cell_idx] <= cell_val;
      end
      d1_rd_ff <= diag1_mem[rd_ff];
   end

   always_ff @(posedge clock) begin
      rdq_ff <= rd_ff;
      rsp_ff <= rsp_in;
      too_long_ff <= too_long_in;
      if (ret_ff) begin
         win_ff <= nv;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         n_ff <= '0;
         len_ff <= '0;
         rd_ff <= '0;
         ret_ff <= 1'b0;
         cell_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff <= n_in;
         len_ff <= len_in;
         rd_ff <= rd_in;
         ret_ff <= issue;
         cell_ff <= issue && (rd_ff != '0);
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

endmodule
`default_nettype wire

FILE: src/min_insertions_to_palindrome.sv
// Throughput: one word per cycle while the four-word queue has room; busy while it is full.
// The result for a string follows its last word through the diagonal sweep, which visits
// each table cell and has a priming and a drain step per diagonal; a single character
// answers straight from the sequencer, without a sweep.
// The result strobe is high for one cycle; the receiver cannot stall.
// Reset clears counters, queue and sequencer; character and diagonal storage is not cleared.
`default_nettype none
module min_insertions_to_palindrome
   import mip_pkg::*;
#(
   parameter int MAX_LEN = MAX_LEN_DEF
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         start,
   input  wire req_word_type req_word,
   output logic              busy,
   output logic              rsp_strobe,
   output rsp_word_type      rsp_word
);

   localparam int ENT_W = 8 + $clog2(MAX_LEN) + $clog2(MAX_LEN + 1) + 3;

   logic             q_push;
   logic             q_pop;
   logic [ENT_W-1:0] push_entry;
   logic [ENT_W-1:0] head_entry;
   q_status_type     q_stat;
   bk_status_type    bk_stat;

   assign busy = q_stat.full;
   assign q_push = start && !busy;

   mip_front #(
      .MAX_LEN (MAX_LEN),
      .ENT_W   (ENT_W)
   ) u_front (
      .clock  (clock),
      .reset  (reset),
      .accept (q_push),
      .word   (req_word),
      .entry  (push_entry)
   );

   mip_queue #(
      .WIDTH (ENT_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (push_entry),
      .pop       (q_pop),
      .pop_data  (head_entry),
      .status    (q_stat)
   );

   mip_back #(
      .MAX_LEN (MAX_LEN),
      .ENT_W   (ENT_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_stat     (q_stat),
      .entry      (head_entry),
      .pop        (q_pop),
      .stat       (bk_stat),
      .rsp_strobe (rsp_strobe),
      .rsp_word   (rsp_word)
   );

   a_no_overfill: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_stat.full)
      else $error("queue written while full");

   a_no_pop_in_sweep: assert property (@(posedge clock) disable iff (reset)
      bk_stat.sweeping |-> !bk_stat.pop)
      else $error("queue popped during sweep");

   a_sweep_after_last: assert property (@(posedge clock) disable iff (reset)
      $rose(bk_stat.sweeping) |-> $past(bk_stat.pop_last))
      else $error("sweep began without a closing word");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(bk_stat.pop_last || bk_stat.sweeping))
      else $error("result without a closing word or sweep");

endmodule
`default_nettype wire
